[hw/rtl/bf3x3_pkg.sv]
package bf3x3_pkg;

  // Line store depth; also the widest frame that the block accepts.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int FW_W   = 11;                      // frame_width register
  localparam int FH_W   = 13;                      // frame_height register
  localparam int COL_W  = $clog2(MAX_WIDTH);       // column counters, line store address
  localparam int ROW_W  = $clog2(MAX_HEIGHT);      // output row counter
  localparam int IROW_W = FH_W;                    // input row runs past the height on flush
  localparam int WU_W   = (FW_W > COL_W) ? FW_W : COL_W + 1;
  localparam int SUM_W  = 12;                      // nine 8-bit terms

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  // floor(sum / 9) == (sum * 7282) >> 16 for every sum up to 9 * 255.
  localparam int RECIP_9     = 7282;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;

  localparam int FIFO_DEPTH = 4;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // One window advance, issued when the line stores are read.
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] pix;
    logic             due;
    logic             top_edge;
    logic             bot_edge;
    logic             left_edge;
    logic             right_edge;
    logic             eof;
  } adv_t;

  // Neighborhood sum of one result.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic             eor;
    logic             eof;
  } wsum_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             eor;
    logic             eof;
  } out_item_t;

endpackage

[hw/rtl/bf3x3_if.sv]
interface bf3x3_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [bf3x3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output operation, output pixel_in, input ready);
  modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

interface bf3x3_out_if;
  logic                         valid;
  logic                         ready;
  logic [bf3x3_pkg::PIX_W-1:0]  pixel_out;
  logic                         end_of_row;
  logic                         end_of_frame;

  modport source (output valid, output pixel_out, output end_of_row, output end_of_frame,
                  input ready);
  modport sink   (input valid, input pixel_out, input end_of_row, input end_of_frame,
                  output ready);
endinterface

[hw/rtl/bf3x3_window.sv]
module bf3x3_window (
  input  logic              clk,
  input  logic              rst_n,
  input  bf3x3_pkg::adv_t   cmd,
  output bf3x3_pkg::wsum_t  sum_o
);
  import bf3x3_pkg::*;

  localparam int RS_W = 10;

  logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];

  adv_t             cmd_r;
  logic [PIX_W-1:0] up_q_r, mid_q_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_up_r, fwd_mid_r;
  logic [PIX_W-1:0] up_e, mid_e;

  // Only two window columns are stored; the incoming column is the third.
  logic [PIX_W-1:0] win_c1_r [3];
  logic [PIX_W-1:0] win_c2_r [3];
  logic [PIX_W-1:0] new_col  [3];
  logic [RS_W-1:0]  row_sum  [3];
  logic [PIX_W-1:0] left_pix, right_pix;
  logic [RS_W-1:0]  top_row, bot_row;

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      up_q_r <= up_mem[cmd.addr];
    end
    if (cmd_r.valid) begin
      up_mem[cmd_r.addr] <= mid_e;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      mid_q_r <= mid_mem[cmd.addr];
    end
    if (cmd_r.valid) begin
      mid_mem[cmd_r.addr] <= cmd_r.pix;
    end
  end

  // A one-pixel-wide frame reads the entry that is being written in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r.valid <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      cmd_r.valid <= cmd.valid;
      fwd_r       <= cmd.valid && cmd_r.valid && (cmd.addr == cmd_r.addr);
    end
    cmd_r.addr       <= cmd.addr;
    cmd_r.pix        <= cmd.pix;
    cmd_r.due        <= cmd.due;
    cmd_r.top_edge   <= cmd.top_edge;
    cmd_r.bot_edge   <= cmd.bot_edge;
    cmd_r.left_edge  <= cmd.left_edge;
    cmd_r.right_edge <= cmd.right_edge;
    cmd_r.eof        <= cmd.eof;
    fwd_up_r         <= mid_e;
    fwd_mid_r        <= cmd_r.pix;
  end

  assign up_e  = fwd_r ? fwd_up_r  : up_q_r;
  assign mid_e = fwd_r ? fwd_mid_r : mid_q_r;

  assign new_col[0] = up_e;
  assign new_col[1] = mid_e;
  assign new_col[2] = cmd_r.pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        win_c1_r[k] <= '0;
        win_c2_r[k] <= '0;
      end
    end else if (cmd_r.valid) begin
      for (int k = 0; k < 3; k++) begin
        win_c1_r[k] <= win_c2_r[k];
        win_c2_r[k] <= new_col[k];
      end
    end
  end

  // The result column is the newest stored column; border replication picks
  // it again in place of a neighbor outside the frame.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      left_pix   = cmd_r.left_edge  ? win_c2_r[k] : win_c1_r[k];
      right_pix  = cmd_r.right_edge ? win_c2_r[k] : new_col[k];
      row_sum[k] = RS_W'(left_pix) + RS_W'(win_c2_r[k]) + RS_W'(right_pix);
    end
    top_row = cmd_r.top_edge ? row_sum[1] : row_sum[0];
    bot_row = cmd_r.bot_edge ? row_sum[1] : row_sum[2];
  end

  assign sum_o.valid = cmd_r.valid && cmd_r.due;
  assign sum_o.sum   = SUM_W'(top_row) + SUM_W'(row_sum[1]) + SUM_W'(bot_row);
  assign sum_o.eor   = cmd_r.right_edge;
  assign sum_o.eof   = cmd_r.eof;

endmodule

[hw/rtl/box_filter_3x3_replicate_top.sv]
// Channel   Dir  Payload                                       Handshake
// in_bus    in   operation, pixel_in                           valid/ready
// out_bus   out  pixel_out, end_of_row, end_of_frame           valid/ready
// cfg_*     in   cfg_index (0 width, 1 height), cfg_wdata      cfg_we, no stall
//
// One beat per clock while in_bus.ready is high; the rate is set by the two line stores, each
// read and written once per cycle. A result passes the window, sum and output queue registers.
// The first drain beat of a one-row frame makes two window advances.
// Reset clears counters, window and the four-entry output queue, not the line stores.
// in_bus.ready drops when queued and in-flight results fill the output queue.
module box_filter_3x3_replicate_top (
  input  logic                               clk,
  input  logic                               rst_n,
  bf3x3_in_if.sink                           in_bus,
  bf3x3_out_if.source                        out_bus,
  input  logic                               cfg_we,
  input  logic [bf3x3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bf3x3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bf3x3_pkg::*;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [IROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              second_r;

  logic [WU_W-1:0]   w_used, in_col_inc;
  logic [FH_W-1:0]   h_used;
  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_last;
  logic              cfg_hit, accept, complete, due, adv_go;
  logic              last_col, last_row, eof_now;
  adv_t              adv;
  wsum_t             wsum;
  wsum_t             s2_r;
  logic [PROD_W-1:0] prod;

  out_item_t         fifo_mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  fifo_cnt_r;
  logic [CNT_W:0]    pending;
  logic              push, pop;

  // Sizes in use, saturated to the supported range.
  always_comb begin
    if (fw_r == '0) begin
      w_used = WU_W'(1);
    end else if (WU_W'(fw_r) > WU_W'(MAX_WIDTH)) begin
      w_used = WU_W'(MAX_WIDTH);
    end else begin
      w_used = WU_W'(fw_r);
    end
    if (fh_r == '0) begin
      h_used = FH_W'(1);
    end else if (fh_r > FH_W'(MAX_HEIGHT)) begin
      h_used = FH_W'(MAX_HEIGHT);
    end else begin
      h_used = fh_r;
    end
  end

  assign w_last = COL_W'(w_used - WU_W'(1));
  assign h_last = ROW_W'(h_used - FH_W'(1));

  assign cfg_hit  = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  assign accept   = in_bus.valid && in_bus.ready;
  assign complete = in_row_r >= IROW_W'(h_used);
  assign due      = (in_row_r >= IROW_W'(2)) || (in_row_r == IROW_W'(1) && in_col_r != '0);
  // Once the frame's input is complete, every beat stands in for flush positions.
  assign adv_go   = second_r || (accept && (complete || in_bus.operation == OP_PUSH));
  assign last_col = out_col_r == w_last;
  assign last_row = out_row_r == h_last;
  assign eof_now  = due && last_col && last_row;

  assign adv.valid      = adv_go;
  assign adv.addr       = in_col_r;
  assign adv.pix        = (second_r || complete) ? '0 : in_bus.pixel_in;
  assign adv.due        = due;
  assign adv.top_edge   = out_row_r == '0;
  assign adv.bot_edge   = last_row;
  assign adv.left_edge  = out_col_r == '0;
  assign adv.right_edge = last_col;
  assign adv.eof        = eof_now;

  assign in_col_inc = WU_W'(in_col_r) + WU_W'(1);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_hit || (adv_go && eof_now)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (adv_go) begin
      if (in_col_inc == w_used) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + IROW_W'(1);
      end else begin
        in_col_nxt = in_col_inc[COL_W-1:0];
      end
      if (due) begin
        if (last_col) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= FRAME_WIDTH_RST;
      fh_r      <= FRAME_HEIGHT_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      second_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_FRAME_WIDTH) begin
        fw_r <= cfg_wdata[FW_W-1:0];
      end
      if (cfg_we && cfg_index == REG_FRAME_HEIGHT) begin
        fh_r <= cfg_wdata[FH_W-1:0];
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      // A flush beat whose first advance yields nothing takes a second advance.
      second_r  <= !second_r && accept && complete && !due;
    end
  end

  bf3x3_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (adv),
    .sum_o (wsum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= wsum.valid;
    end
    s2_r.sum <= wsum.sum;
    s2_r.eor <= wsum.eor;
    s2_r.eof <= wsum.eof;
  end

  assign prod = PROD_W'(s2_r.sum) * PROD_W'(RECIP_9);

  // Output queue. Credits count every result that is queued or still in flight.
  assign push    = s2_r.valid;
  assign pop     = out_bus.valid && out_bus.ready;
  assign pending = (CNT_W + 1)'(fifo_cnt_r) + (CNT_W + 1)'(wsum.valid)
                   + (CNT_W + 1)'(s2_r.valid);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[wr_ptr_r].pix <= prod[RECIP_SHIFT +: PIX_W];
      fifo_mem_r[wr_ptr_r].eor <= s2_r.eor;
      fifo_mem_r[wr_ptr_r].eof <= s2_r.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fifo_cnt_r <= fifo_cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        fifo_cnt_r <= fifo_cnt_r - CNT_W'(1);
      end
    end
  end

  assign in_bus.ready         = !second_r && (pending < (CNT_W + 1)'(FIFO_DEPTH));
  assign out_bus.valid        = fifo_cnt_r != '0;
  assign out_bus.pixel_out    = fifo_mem_r[rd_ptr_r].pix;
  assign out_bus.end_of_row   = fifo_mem_r[rd_ptr_r].eor;
  assign out_bus.end_of_frame = fifo_mem_r[rd_ptr_r].eof;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s2_r.valid |-> (fifo_cnt_r < CNT_W'(FIFO_DEPTH)) || pop)
    else $error("result reached a full output queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("output queue count beyond its depth");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> $past(in_bus.valid && in_bus.ready))
    else $error("second advance without a preceding beat");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_go && eof_now) |=> (in_row_r == '0 && out_row_r == '0 && in_col_r == '0))
    else $error("positions not cleared after the last result of a frame");
`endif

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bf3x3_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_BEATS  = 900;
  localparam int QUIET_BEATS   = 300;

  // Register indexes that the block decodes as nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bf3x3_in_if  in_bus ();
  bf3x3_out_if out_bus ();

  box_filter_3x3_replicate_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Filter state as the block should hold it.
  bit [PIX_W-1:0]  line_up2 [MAX_WIDTH];
  bit [PIX_W-1:0]  line_up1 [MAX_WIDTH];
  bit [PIX_W-1:0]  win [9];
  int unsigned     pix_col;
  int unsigned     pix_row;
  int unsigned     res_col;
  int unsigned     res_row;
  logic [FW_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [FH_W-1:0] height_reg = FRAME_HEIGHT_RST;

  out_item_t   pending_means [$];
  out_item_t   got;
  out_item_t   want;
  int unsigned mismatches;
  int unsigned beats_used;
  int unsigned idle_cycles;
  int unsigned hold_left;
  bit          send_gaps;
  bit          recv_stalls;
  bit          hold_req;

  function automatic int unsigned frame_w();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    if (height_reg == '0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void rewind_frame();
    pix_col = 0;
    pix_row = 0;
    res_col = 0;
    res_row = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = data[FW_W-1:0];
      rewind_frame();
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = data[FH_W-1:0];
      rewind_frame();
    end
  endfunction

  // Slide the window one column and rotate the two line stores at that column.
  function automatic void shift_window(int unsigned col, logic [PIX_W-1:0] pix);
    int unsigned    a;
    bit [PIX_W-1:0] up;
    bit [PIX_W-1:0] mid;
    a   = col % MAX_WIDTH;
    up  = line_up2[a];
    mid = line_up1[a];
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = pix;
    line_up2[a] = mid;
    line_up1[a] = pix;
  endfunction

  // Border rows and columns are folded back onto the result's own row or column.
  function automatic int unsigned box_mean(int centre, int unsigned r, int unsigned c,
                                           int unsigned w, int unsigned h);
    int          cols [3];
    int unsigned sum;
    int          er;
    sum     = 0;
    cols[0] = (c == 0) ? centre : centre - 1;
    cols[1] = centre;
    cols[2] = (c == w - 1 || centre >= 2) ? centre : centre + 1;
    for (int rr = 0; rr < 3; rr++) begin
      er = rr;
      if (rr == 0 && r == 0) er = 1;
      if (rr == 2 && r == h - 1) er = 1;
      for (int k = 0; k < 3; k++) sum += win[er*3 + cols[k]];
    end
    return sum / 9;
  endfunction

  function automatic bit step_window(logic [PIX_W-1:0] pix, output out_item_t res);
    int unsigned w;
    int unsigned h;
    int unsigned ci;
    int unsigned r;
    int unsigned c;
    int unsigned val;
    bit          due;
    w   = frame_w();
    h   = frame_h();
    ci  = pix_col;
    due = (pix_row >= 2) || (pix_row == 1 && ci >= 1);
    r   = res_row;
    c   = res_col;
    val = 0;
    res = '0;
    // At the right edge the mean is taken before the next row's column comes in.
    if (due && c == w - 1) begin
      val = box_mean(2, r, c, w, h);
      shift_window(ci, pix);
    end else begin
      shift_window(ci, pix);
      if (due) val = box_mean(1, r, c, w, h);
    end
    pix_col++;
    if (pix_col >= w) begin
      pix_col = 0;
      pix_row++;
    end
    if (!due) return 1'b0;
    res.pix = val[PIX_W-1:0];
    res.eor = (c == w - 1);
    res.eof = (c == w - 1 && r == h - 1);
    if (res.eof) begin
      rewind_frame();
    end else if (res.eor) begin
      res_col = 0;
      res_row++;
    end else begin
      res_col++;
    end
    return 1'b1;
  endfunction

  // Returns 0 when the beat is ignored by the block.
  function automatic bit predict_beat(op_t op, logic [PIX_W-1:0] pix);
    out_item_t res;
    bit        done;
    done = (pix_row >= frame_h());
    if (op == OP_PUSH && !done) begin
      if (step_window(pix, res)) pending_means = {pending_means, res};
      return 1'b1;
    end
    if (!done) return 1'b0;
    for (int i = 0; i < 2; i++) begin
      if (step_window('0, res)) begin
        pending_means = {pending_means, res};
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.pix = out_bus.pixel_out;
      got.eor = out_bus.end_of_row;
      got.eof = out_bus.end_of_frame;
      if (pending_means.size() == 0) begin
        $error("result beat with nothing expected: pixel_out %0d", got.pix);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (got.pix !== want.pix) begin
          $error("pixel_out: expected %0d, got %0d", want.pix, got.pix);
          mismatches++;
        end
        if (got.eor !== want.eor) begin
          $error("end_of_row: expected %0b, got %0b", want.eor, got.eor);
          mismatches++;
        end
        if (got.eof !== want.eof) begin
          $error("end_of_frame: expected %0b, got %0b", want.eof, got.eof);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req      = 1'b0;
      hold_left     = HOLD_CYCLES - 1;
      out_bus.ready = 1'b0;
    end else begin
      out_bus.ready = !(recv_stalls && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input op_t op, input logic [PIX_W-1:0] pix);
    @(negedge clk);
    while (send_gaps && $urandom_range(99) < 10) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.operation = op;
    in_bus.pixel_in  = pix;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (predict_beat(op, pix)) beats_used++;
  endtask

  // Wait until every expected result is out and the pipeline has gone quiet.
  task automatic settle_block();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    settle_block();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic flush_frame();
    while (pix_row >= frame_h())
      send_beat(op_t'(($urandom_range(3) == 0) ? OP_PUSH : OP_DRAIN), rand_pixel());
  endtask

  task automatic run_frame(input bit abandon, input int unsigned noise_pct);
    int unsigned total;
    int unsigned stop;
    total = frame_w() * frame_h();
    stop  = abandon ? $urandom_range(total) : total;
    for (int unsigned i = 0; i < stop; i++) begin
      // A drain in mid-frame is ignored by the block.
      if ($urandom_range(99) < noise_pct) send_beat(OP_DRAIN, rand_pixel());
      send_beat(OP_PUSH, rand_pixel());
    end
    if (!abandon) flush_frame();
  endtask

  // Default 640-pixel rows: results start only after a full row and one pixel.
  task automatic test_reset_sizes();
    for (int i = 0; i < 700; i++) send_beat(OP_PUSH, rand_pixel());
    settle_block();
  endtask

  task automatic test_corner_frames();
    logic [PIX_W-1:0] pattern [9];
    pattern = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) begin
      send_beat(OP_PUSH, pattern[i]);
      if (i == 2) send_beat(OP_DRAIN, 8'hA5);
      if (i == 4) begin
        // Writes to undecoded indexes must leave the frame position alone.
        settle_block();
        write_reg(REG_UNUSED_2, '1);
        write_reg(REG_UNUSED_3, CFG_DATA_W'(5));
      end
    end
    send_beat(OP_PUSH, 8'h5A);
    while (pix_row >= frame_h()) send_beat(OP_DRAIN, '0);
    set_frame(1, 1);
    send_beat(OP_PUSH, 8'd255);
    while (pix_row >= frame_h()) send_beat(OP_DRAIN, '1);
    set_frame(2, 1);
    send_beat(OP_PUSH, 8'd0);
    send_beat(OP_PUSH, 8'd255);
    while (pix_row >= frame_h()) send_beat(OP_DRAIN, '0);
    set_frame(1, 3);
    send_beat(OP_PUSH, 8'd7);
    send_beat(OP_PUSH, 8'd255);
    send_beat(OP_PUSH, 8'd128);
    while (pix_row >= frame_h()) send_beat(OP_DRAIN, '0);
  endtask

  task automatic test_size_limits();
    set_frame(0, 0);
    run_frame(1'b0, 0);
    // Oversized widths clamp to the line store depth, so no result shows up early.
    set_frame(2047, 1);
    for (int i = 0; i < 24; i++) send_beat(OP_PUSH, rand_pixel());
    set_frame(1025, 8191);
    for (int i = 0; i < 24; i++) send_beat(OP_PUSH, rand_pixel());
    set_frame(1, 8191);
    for (int i = 0; i < 24; i++) send_beat(OP_PUSH, rand_pixel());
  endtask

  task automatic test_output_holdoff();
    set_frame(4, 3);
    hold_req = 1'b1;
    repeat (4) run_frame(1'b0, 0);
    settle_block();
  endtask

  task automatic test_random_frames();
    int unsigned goal;
    int unsigned quiet_end;
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    int unsigned pick;
    goal        = beats_used + RANDOM_BEATS;
    quiet_end   = beats_used + QUIET_BEATS;
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    while (beats_used < goal) begin
      if (beats_used >= quiet_end) begin
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
      end
      pick = $urandom_range(99);
      w    = (pick < 60) ? $urandom_range(1, 6) :
             (pick < 90) ? $urandom_range(7, 24) : $urandom_range(25, 64);
      pick = $urandom_range(99);
      h    = (pick < 60) ? $urandom_range(1, 4) :
             (pick < 90) ? $urandom_range(5, 8) : $urandom_range(9, 16);
      if (w > 24) h = $urandom_range(1, 3);
      settle_block();
      case ($urandom_range(3))
        0:       write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        1:       write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        default: begin
          write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
          write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        end
      endcase
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_DATA_W'($urandom));
      // Keep the previous height from making a wide frame too tall.
      if (frame_w() * frame_h() > 1024) write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++)
        run_frame(f == frames - 1 && $urandom_range(99) < 15, 5);
    end
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
  endtask

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_PUSH;
    in_bus.pixel_in  = '0;
    out_bus.ready    = 1'b0;
    send_gaps        = 1'b1;
    recv_stalls      = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_sizes();
    test_corner_frames();
    test_size_limits();
    test_output_holdoff();
    test_random_frames();

    settle_block();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[box_filter_3x3_replicate_top.f]
hw/rtl/bf3x3_pkg.sv
hw/rtl/bf3x3_if.sv
hw/rtl/bf3x3_window.sv
hw/rtl/box_filter_3x3_replicate_top.sv
verif/tb.sv
